FILE: hw/rtl/fxalu_pkg.sv
// ----------------------------------------------------------------------------
// fxalu_pkg
// Word width, operation codes and saturation helper for the Q24.8 ALU.
// ----------------------------------------------------------------------------
package fxalu_pkg;

   localparam int WORD_BITS = 32;
   localparam int MAG_BITS  = 2 * WORD_BITS;

   typedef enum logic [3:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_DIV      = 4'd3,
      OP_MIN      = 4'd4,
      OP_MAX      = 4'd5,
      OP_INC      = 4'd6,
      OP_DEC      = 4'd7,
      OP_TO_INT   = 4'd8,
      OP_FROM_INT = 4'd9
   } op_type;

   typedef struct packed {
      logic less;
      logic equal;
      logic greater;
   } cmp_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] value;
      logic                 ovf;
   } sat_type;

   localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam logic [MAG_BITS-1:0]  MAG_MAX  = MAG_BITS'(WORD_MAX);
   localparam logic [MAG_BITS-1:0]  MAG_MIN  = MAG_BITS'(WORD_MAX) + MAG_BITS'(1);

   // Apply a sign to a magnitude and clamp to the signed word range.
   function automatic sat_type saturate(input logic neg, input logic [MAG_BITS-1:0] mag);
      sat_type r;
      r.ovf = 1'b0;
      if (neg) begin
         if (mag > MAG_MAX) begin
            r.value = WORD_MIN;
            r.ovf   = (mag > MAG_MIN);
         end else begin
            r.value = (~mag[WORD_BITS-1:0]) + WORD_BITS'(1);
         end
      end else if (mag > MAG_MAX) begin
         r.value = WORD_MAX;
         r.ovf   = 1'b1;
      end else begin
         r.value = mag[WORD_BITS-1:0];
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/fixed_point_q24_8_alu_top.sv
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_top: pipelined signed fixed-point ALU
// Q24.8 operands; restoring divider, one quotient bit per stage. Throughput one
// word per cycle for every op, while the output word is not held waiting.
// Synchronous reset clears all stage valid bits; payload is not reset.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_top #(
   parameter int FRAC_BITS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [3:0]                             req_kind,
   input  logic signed [fxalu_pkg::WORD_BITS-1:0] req_operand_a,
   input  logic signed [fxalu_pkg::WORD_BITS-1:0] req_operand_b,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [fxalu_pkg::WORD_BITS-1:0] rsp_result,
   output logic                                   rsp_a_less,
   output logic                                   rsp_a_equal,
   output logic                                   rsp_a_greater,
   output logic                                   rsp_overflowed,
   output logic                                   rsp_divide_by_zero
);

   localparam int W  = fxalu_pkg::WORD_BITS;
   localparam int MB = fxalu_pkg::MAG_BITS;
   localparam int QB = W + FRAC_BITS + 1;   // dividend / quotient bits

   typedef struct packed {
      fxalu_pkg::op_type  kind;
      fxalu_pkg::cmp_type cmp;
      logic [W-1:0]       a;
      logic [W-1:0]       b;
      logic [W-1:0]       am;
      logic [W-1:0]       bm;
   } front_type;

   typedef struct packed {
      fxalu_pkg::op_type  kind;
      fxalu_pkg::cmp_type cmp;
      logic               a_neg;
      logic               neg;
      logic               dz;
      logic [W-1:0]       res;
      logic               ovf;
      logic [MB-1:0]      prod;
      logic [QB-1:0]      quo;
      logic [W:0]         dvs;
   } mid_type;

   typedef struct packed {
      fxalu_pkg::op_type  kind;
      fxalu_pkg::cmp_type cmp;
      logic               a_neg;
      logic               neg;
      logic               dz;
      logic [W-1:0]       res;
      logic               ovf;
      logic [QB-1:0]      quo;
      logic [W:0]         rem;
      logic [W:0]         dvs;
   } div_stage_type;

   typedef struct packed {
      fxalu_pkg::cmp_type cmp;
      logic [W-1:0]       res;
      logic               ovf;
      logic               dz;
   } out_type;

   logic          advance;
   front_type     s1_ff, s1_in;
   logic          s1_valid_ff;
   mid_type       s2_ff, s2_in;
   logic          s2_valid_ff;
   div_stage_type div_ff [QB+1];
   div_stage_type div_in [QB+1];
   logic          div_valid_ff [QB+1];
   out_type       out_ff, out_in;
   logic          out_valid_ff;

   // Whole pipe moves together; it holds only when the output word waits.
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;

   // ---- stage 1: decode, compare, magnitudes
   always_comb begin
      s1_in.kind        = fxalu_pkg::op_type'(req_kind);
      s1_in.cmp.less    = req_operand_a < req_operand_b;
      s1_in.cmp.equal   = req_operand_a == req_operand_b;
      s1_in.cmp.greater = req_operand_a > req_operand_b;
      s1_in.a           = req_operand_a;
      s1_in.b           = req_operand_b;
      s1_in.am          = req_operand_a[W-1] ? (~req_operand_a) + W'(1) : req_operand_a;
      s1_in.bm          = req_operand_b[W-1] ? (~req_operand_b) + W'(1) : req_operand_b;
   end

   // ---- stage 2: add/sub/inc/dec, min/max, conversions, product, divider setup
   logic [W:0]             s2_addend;
   logic                   s2_carry;
   logic [W:0]             s2_sum;
   fxalu_pkg::sat_type     s2_from_int;
   logic [W-1:0]           s2_trunc;

   always_comb begin
      s2_addend = {s1_ff.b[W-1], s1_ff.b};
      s2_carry  = 1'b0;
      case (s1_ff.kind)
         fxalu_pkg::OP_SUB: begin
            s2_addend = ~{s1_ff.b[W-1], s1_ff.b};
            s2_carry  = 1'b1;
         end
         fxalu_pkg::OP_INC: s2_addend = (W+1)'(1);
         fxalu_pkg::OP_DEC: s2_addend = {(W+1){1'b1}};
         default:           s2_addend = {s1_ff.b[W-1], s1_ff.b};
      endcase
      s2_sum      = {s1_ff.a[W-1], s1_ff.a} + s2_addend + (W+1)'(s2_carry);
      s2_from_int = fxalu_pkg::saturate(s1_ff.a[W-1], MB'(s1_ff.am) << FRAC_BITS);
      s2_trunc    = s1_ff.am >> FRAC_BITS;

      s2_in.kind  = s1_ff.kind;
      s2_in.cmp   = s1_ff.cmp;
      s2_in.a_neg = s1_ff.a[W-1];
      s2_in.neg   = s1_ff.a[W-1] ^ s1_ff.b[W-1];
      s2_in.dz    = (s1_ff.kind == fxalu_pkg::OP_DIV) && (s1_ff.bm == '0);
      s2_in.prod  = MB'(s1_ff.am) * MB'(s1_ff.bm);
      s2_in.quo   = {s1_ff.am, {(FRAC_BITS+1){1'b0}}} + QB'(s1_ff.bm);
      s2_in.dvs   = {s1_ff.bm, 1'b0};
      s2_in.res   = '0;
      s2_in.ovf   = 1'b0;

      case (s1_ff.kind)
         fxalu_pkg::OP_ADD, fxalu_pkg::OP_SUB, fxalu_pkg::OP_INC, fxalu_pkg::OP_DEC: begin
            if (s2_sum[W] != s2_sum[W-1]) begin
               s2_in.res = s2_sum[W] ? fxalu_pkg::WORD_MIN : fxalu_pkg::WORD_MAX;
               s2_in.ovf = 1'b1;
            end else begin
               s2_in.res = s2_sum[W-1:0];
            end
         end
         fxalu_pkg::OP_MIN:    s2_in.res = s1_ff.cmp.less ? s1_ff.a : s1_ff.b;
         fxalu_pkg::OP_MAX:    s2_in.res = s1_ff.cmp.greater ? s1_ff.a : s1_ff.b;
         fxalu_pkg::OP_TO_INT: s2_in.res = s1_ff.a[W-1] ? (~s2_trunc) + W'(1) : s2_trunc;
         fxalu_pkg::OP_FROM_INT: begin
            s2_in.res = s2_from_int.value;
            s2_in.ovf = s2_from_int.ovf;
         end
         default: s2_in.res = '0;
      endcase
   end

   // ---- stage 3: round and clamp the product, enter the divider
   logic [MB-1:0]      s3_round;
   fxalu_pkg::sat_type s3_mul;

   always_comb begin
      s3_round = (s2_ff.prod + (MB'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      s3_mul   = fxalu_pkg::saturate(s2_ff.neg, s3_round);

      div_in[0].kind  = s2_ff.kind;
      div_in[0].cmp   = s2_ff.cmp;
      div_in[0].a_neg = s2_ff.a_neg;
      div_in[0].neg   = s2_ff.neg;
      div_in[0].dz    = s2_ff.dz;
      div_in[0].quo   = s2_ff.quo;
      div_in[0].rem   = '0;
      div_in[0].dvs   = s2_ff.dvs;
      if (s2_ff.kind == fxalu_pkg::OP_MUL) begin
         div_in[0].res = s3_mul.value;
         div_in[0].ovf = s3_mul.ovf;
      end else begin
         div_in[0].res = s2_ff.res;
         div_in[0].ovf = s2_ff.ovf;
      end
   end

   // ---- divider: restoring, one quotient bit per stage
   for (genvar i = 0; i < QB; i++) begin : g_div
      logic [W+1:0] shifted;
      logic [W+1:0] diff;
      logic         take;

      always_comb begin
         shifted         = {div_ff[i].rem, div_ff[i].quo[QB-1]};
         diff            = shifted - {1'b0, div_ff[i].dvs};
         take            = shifted >= {1'b0, div_ff[i].dvs};
         div_in[i+1]     = div_ff[i];
         div_in[i+1].rem = take ? diff[W:0] : shifted[W:0];
         div_in[i+1].quo = {div_ff[i].quo[QB-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_valid_ff[i+1] <= 1'b0;
         end else if (advance) begin
            div_valid_ff[i+1] <= div_valid_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            div_ff[i+1] <= div_in[i+1];
         end
      end
   end

   // ---- output stage: clamp the quotient, handle a zero divisor
   fxalu_pkg::sat_type q_sat;

   always_comb begin
      q_sat      = fxalu_pkg::saturate(div_ff[QB].neg, MB'(div_ff[QB].quo));
      out_in.cmp = div_ff[QB].cmp;
      out_in.dz  = div_ff[QB].dz;
      out_in.res = div_ff[QB].res;
      out_in.ovf = div_ff[QB].ovf;
      if (div_ff[QB].kind == fxalu_pkg::OP_DIV) begin
         if (div_ff[QB].dz) begin
            out_in.res = div_ff[QB].a_neg ? fxalu_pkg::WORD_MIN : fxalu_pkg::WORD_MAX;
            out_in.ovf = 1'b0;
         end else begin
            out_in.res = q_sat.value;
            out_in.ovf = q_sat.ovf;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         div_valid_ff[0] <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else if (advance) begin
         s1_valid_ff     <= req_valid;
         s2_valid_ff     <= s1_valid_ff;
         div_valid_ff[0] <= s2_valid_ff;
         out_valid_ff    <= div_valid_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff     <= s1_in;
         s2_ff     <= s2_in;
         div_ff[0] <= div_in[0];
         out_ff    <= out_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_result         = out_ff.res;
   assign rsp_a_less         = out_ff.cmp.less;
   assign rsp_a_equal        = out_ff.cmp.equal;
   assign rsp_a_greater      = out_ff.cmp.greater;
   assign rsp_overflowed     = out_ff.ovf;
   assign rsp_divide_by_zero = out_ff.dz;

endmodule

FILE: test/fixed_point_q24_8_alu_top_tb.sv
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_top_tb
// Drives operation words into the Q24.8 ALU through a valid/ready channel and
// checks every returned word, field by field, in order. A short table of
// corner cases comes first, then randomized operations. Both sides idle at
// random, with one idle-free window and one long receiver hold-off that backs
// up the pipeline. Expected words: fixed rows, else an exact fixed-point model.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_top_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC        = 8;
   localparam int NUM_DIR     = 25;
   localparam int RAND_ITEMS  = 1750;
   localparam int IDLE_PCT    = 23;
   localparam int QUIET_FROM  = 900;
   localparam int QUIET_TO    = 1200;
   localparam int HOLD_AT     = 400;
   localparam int HOLD_CYCLES = 250;
   localparam int DRAIN_WAIT  = 60;
   localparam int CYCLE_LIMIT = 200000;

   localparam logic [3:0] KIND_SPARE_LO = 4'hA;
   localparam logic [3:0] KIND_SPARE_HI = 4'hF;

   localparam logic [63:0] MAG_HI = 64'h0000_0000_7FFF_FFFF;

   typedef struct packed {
      logic [31:0] result;
      logic        less;
      logic        equal;
      logic        greater;
      logic        ovf;
      logic        dz;
   } alu_word_type;

   typedef struct packed {
      logic [31:0] value;
      logic        ovf;
   } clamp_type;

   typedef struct packed {
      logic [3:0]   kind;
      logic [31:0]  a;
      logic [31:0]  b;
      logic         fixed;
      alu_word_type want;
   } row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [3:0]           req_kind = 4'd0;
   logic signed [31:0]   req_operand_a = 32'd0;
   logic signed [31:0]   req_operand_b = 32'd0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic signed [31:0]   rsp_result;
   logic                 rsp_a_less;
   logic                 rsp_a_equal;
   logic                 rsp_a_greater;
   logic                 rsp_overflowed;
   logic                 rsp_divide_by_zero;

   alu_word_type pending_alu_words[$];
   int           mismatch_cnt = 0;
   int           accepted_cnt = 0;
   int           returned_cnt = 0;
   int           cycle_cnt    = 0;
   int           hold_left    = 0;
   bit           held_off     = 1'b0;
   row_type      dir_rows[NUM_DIR];

   fixed_point_q24_8_alu_top u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_operand_a      (req_operand_a),
      .req_operand_b      (req_operand_b),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result         (rsp_result),
      .rsp_a_less         (rsp_a_less),
      .rsp_a_equal        (rsp_a_equal),
      .rsp_a_greater      (rsp_a_greater),
      .rsp_overflowed     (rsp_overflowed),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   always #2 clock = ~clock;

   // Sign a magnitude and clamp to the 32-bit range; exact minimum is no overflow.
   function automatic clamp_type clamp_mag(input logic neg, input logic [63:0] mag);
      clamp_type c;
      c.ovf = 1'b0;
      if (neg) begin
         if (mag > MAG_HI) begin
            c.value = 32'h8000_0000;
            c.ovf   = (mag > MAG_HI + 64'd1);
         end else begin
            c.value = -mag[31:0];
         end
      end else if (mag > MAG_HI) begin
         c.value = 32'h7FFF_FFFF;
         c.ovf   = 1'b1;
      end else begin
         c.value = mag[31:0];
      end
      return c;
   endfunction

   function automatic clamp_type clamp_signed(input logic signed [63:0] v);
      logic [63:0] mag;
      mag = (v < 0) ? 64'(-v) : 64'(v);
      return clamp_mag(v < 0, mag);
   endfunction

   function automatic alu_word_type alu_compute(input logic [3:0] kind,
                                                input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      alu_word_type       w;
      clamp_type          c;
      logic signed [63:0] a_w;
      logic signed [63:0] b_w;
      logic               a_neg;
      logic               b_neg;
      logic [63:0]        am;
      logic [63:0]        bm;
      logic [63:0]        t;
      a_w   = a;
      b_w   = b;
      a_neg = (a < 0);
      b_neg = (b < 0);
      am    = a_neg ? 64'(-a_w) : 64'(a_w);
      bm    = b_neg ? 64'(-b_w) : 64'(b_w);
      c     = '0;
      w     = '0;
      case (kind)
         fxalu_pkg::OP_ADD: c = clamp_signed(a_w + b_w);
         fxalu_pkg::OP_SUB: c = clamp_signed(a_w - b_w);
         fxalu_pkg::OP_MUL: begin
            t = ((am * bm) + (64'd1 << (FRAC - 1))) >> FRAC;
            c = clamp_mag(a_neg != b_neg, t);
         end
         fxalu_pkg::OP_DIV: begin
            if (bm == 64'd0) begin
               w.dz    = 1'b1;
               c.value = a_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
               t = (((am << FRAC) << 1) + bm) / (bm << 1);
               c = clamp_mag(a_neg != b_neg, t);
            end
         end
         fxalu_pkg::OP_MIN: c.value = (a < b) ? a : b;
         fxalu_pkg::OP_MAX: c.value = (a > b) ? a : b;
         fxalu_pkg::OP_INC: c = clamp_signed(a_w + 64'sd1);
         fxalu_pkg::OP_DEC: c = clamp_signed(a_w - 64'sd1);
         fxalu_pkg::OP_TO_INT: begin
            t = am >> FRAC;
            c.value = a_neg ? -t[31:0] : t[31:0];
         end
         fxalu_pkg::OP_FROM_INT: c = clamp_mag(a_neg, am << FRAC);
         default: c = '0;
      endcase
      w.result  = c.value;
      w.ovf     = c.ovf;
      w.less    = (a < b);
      w.equal   = (a == b);
      w.greater = (a > b);
      return w;
   endfunction

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0: case ($urandom_range(0, 4))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               3: return 32'h0000_0001;
               default: return 32'hFFFF_FFFF;
            endcase
         1, 2, 3: return 32'($urandom_range(0, 4095)) - 32'd2048;
         4, 5:    return 32'($urandom_range(0, (1 << 21) - 1)) - 32'h0010_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic bit steady_flow();
      return (accepted_cnt >= QUIET_FROM) && (accepted_cnt < QUIET_TO);
   endfunction

   task automatic flag_mismatch(input string field, input logic [31:0] got,
                                input logic [31:0] want);
      $display("word %0d: %s got %h want %h", returned_cnt, field, got, want);
      mismatch_cnt++;
   endtask

   // Offer one word, hold it until taken, then queue its expected result.
   task automatic send_word(input logic [3:0] kind, input logic [31:0] a,
                            input logic [31:0] b, input logic fixed,
                            input alu_word_type want);
      while (!steady_flow() && ($urandom_range(0, 99) < IDLE_PCT)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_operand_a <= a;
      req_operand_b <= b;
      do @(posedge clock); while (!req_ready);
      pending_alu_words.push_back(fixed ? want : alu_compute(kind, a, b));
      accepted_cnt++;
   endtask

   // Receiver: random stalls, one long hold-off, idle-free in the steady window.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (!held_off && accepted_cnt >= HOLD_AT) begin
            held_off  = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (steady_flow()) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin
      alu_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_alu_words.size() == 0) begin
            flag_mismatch("unexpected word, result", rsp_result, 32'd0);
         end else begin
            want = pending_alu_words.pop_front();
            if (rsp_result !== want.result)
               flag_mismatch("result", rsp_result, want.result);
            if (rsp_a_less !== want.less)
               flag_mismatch("a_less", 32'(rsp_a_less), 32'(want.less));
            if (rsp_a_equal !== want.equal)
               flag_mismatch("a_equal", 32'(rsp_a_equal), 32'(want.equal));
            if (rsp_a_greater !== want.greater)
               flag_mismatch("a_greater", 32'(rsp_a_greater), 32'(want.greater));
            if (rsp_overflowed !== want.ovf)
               flag_mismatch("overflowed", 32'(rsp_overflowed), 32'(want.ovf));
            if (rsp_divide_by_zero !== want.dz)
               flag_mismatch("divide_by_zero", 32'(rsp_divide_by_zero), 32'(want.dz));
         end
         returned_cnt++;
      end
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      logic [3:0]  kind;
      logic [31:0] a;
      logic [31:0] b;

      // kind, a, b, fixed, {result, less, equal, greater, ovf, dz}
      dir_rows[0]  = row_type'{fxalu_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1,
                        alu_word_type'{32'h7FFF_FFFF, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}};
      dir_rows[1]  = row_type'{fxalu_pkg::OP_SUB, 32'h8000_0000, 32'h0000_0001, 1'b1,
                        alu_word_type'{32'h8000_0000, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0}};
      dir_rows[2]  = row_type'{fxalu_pkg::OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1,
                        alu_word_type'{32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0}};
      dir_rows[3]  = row_type'{fxalu_pkg::OP_MUL, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1,
                        alu_word_type'{32'h8000_0000, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0}};
      dir_rows[4]  = row_type'{fxalu_pkg::OP_DIV, 32'h0000_0100, 32'h0000_0000, 1'b1,
                        alu_word_type'{32'h7FFF_FFFF, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1}};
      dir_rows[5]  = row_type'{fxalu_pkg::OP_DIV, 32'h8000_0000, 32'h0000_0000, 1'b1,
                        alu_word_type'{32'h8000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1}};
      dir_rows[6]  = row_type'{fxalu_pkg::OP_DIV, 32'h0000_0000, 32'h0000_0000, 1'b1,
                        alu_word_type'{32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1}};
      dir_rows[7]  = row_type'{fxalu_pkg::OP_MIN, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1,
                        alu_word_type'{32'h8000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}};
      dir_rows[8]  = row_type'{fxalu_pkg::OP_MAX, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1,
                        alu_word_type'{32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}};
      dir_rows[9]  = row_type'{fxalu_pkg::OP_INC, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1,
                        alu_word_type'{32'h7FFF_FFFF, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}};
      dir_rows[10] = row_type'{fxalu_pkg::OP_DEC, 32'h8000_0000, 32'h0000_0000, 1'b1,
                        alu_word_type'{32'h8000_0000, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0}};
      dir_rows[11] = row_type'{fxalu_pkg::OP_TO_INT, 32'h8000_0000, 32'h0000_0000, 1'b1,
                        alu_word_type'{32'hFF80_0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}};
      dir_rows[12] = row_type'{fxalu_pkg::OP_FROM_INT, 32'h0080_0000, 32'h0000_0000, 1'b1,
                        alu_word_type'{32'h7FFF_FFFF, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}};
      // lands exactly on the minimum: clamps without overflow
      dir_rows[13] = row_type'{fxalu_pkg::OP_FROM_INT, 32'hFF80_0000, 32'h0000_0000, 1'b1,
                        alu_word_type'{32'h8000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}};
      dir_rows[14] = row_type'{KIND_SPARE_HI, 32'h0000_0005, 32'h0000_0005, 1'b1,
                        alu_word_type'{32'h0000_0000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}};
      dir_rows[15] = row_type'{KIND_SPARE_LO, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
                        alu_word_type'{32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}};
      dir_rows[16] = row_type'{fxalu_pkg::OP_MUL, 32'h0000_0180, 32'h0000_0001, 1'b0, '0};
      dir_rows[17] = row_type'{fxalu_pkg::OP_MUL, 32'hFFFF_FF80, 32'h0000_0001, 1'b0, '0};
      dir_rows[18] = row_type'{fxalu_pkg::OP_DIV, 32'h0000_0100, 32'h0000_0300, 1'b0, '0};
      dir_rows[19] = row_type'{fxalu_pkg::OP_DIV, 32'h8000_0000, 32'hFFFF_FF00, 1'b0, '0};
      dir_rows[20] = row_type'{fxalu_pkg::OP_DIV, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0, '0};
      dir_rows[21] = row_type'{fxalu_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0};
      dir_rows[22] = row_type'{fxalu_pkg::OP_TO_INT, 32'hFFFF_FF01, 32'h0000_0000, 1'b0, '0};
      dir_rows[23] = row_type'{fxalu_pkg::OP_SUB, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0};
      dir_rows[24] = row_type'{fxalu_pkg::OP_MIN, 32'h1234_5678, 32'h1234_5678, 1'b0, '0};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_DIR; i++)
         send_word(dir_rows[i].kind, dir_rows[i].a, dir_rows[i].b,
                   dir_rows[i].fixed, dir_rows[i].want);

      for (int i = 0; i < RAND_ITEMS; i++) begin
         if ($urandom_range(0, 99) < 6)
            kind = 4'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
         else
            kind = 4'($urandom_range(fxalu_pkg::OP_ADD, fxalu_pkg::OP_FROM_INT));
         a = pick_operand();
         b = pick_operand();
         send_word(kind, a, b, 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (pending_alu_words.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_cnt == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/fxalu_pkg.sv
hw/rtl/fixed_point_q24_8_alu_top.sv
test/fixed_point_q24_8_alu_top_tb.sv
